/* design/assert_macros.svh */
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define PHRQ_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// property checked at every clock edge, reset included
`define PHRQ_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

/* design/phrq_pkg.sv */
// shared types and constants for the per-hart run queue block
`default_nettype none

package phrq_pkg;

  localparam int HART_COUNT_DEF = 8;
  localparam int NODE_COUNT_DEF = 256;
  localparam int CMDQ_DEPTH     = 2;

  typedef enum logic [1:0] {
    MODE_BIND = 2'd0,
    MODE_PUSH = 2'd1,
    MODE_POP  = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    OP_BIND,
    OP_PUSH,
    OP_POP,
    OP_FAIL
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_OWNER,
    ST_LINK,
    ST_POP
  } state_t;

  typedef struct packed {
    op_t         op;
    logic [7:0]  node;
    logic [15:0] hart;
    logic        hart_ok;
  } cmd_t;

endpackage

`default_nettype wire

/* design/phrq_front.sv */
// front end: takes commands and classifies them into queue entries
`default_nettype none

module phrq_front #(
  parameter int HART_COUNT = phrq_pkg::HART_COUNT_DEF,
  parameter int NODE_COUNT = phrq_pkg::NODE_COUNT_DEF
) (
  input  wire logic          start,
  input  wire logic [1:0]    mode,
  input  wire logic [7:0]    node_index,
  input  wire logic [15:0]   hart,
  input  wire logic          full,
  output logic               busy,
  output logic               push,
  output phrq_pkg::cmd_t     cmd
);

  logic node_ok;
  logic hart_ok;

  assign node_ok = int'(node_index) < NODE_COUNT;
  assign hart_ok = int'(hart) < HART_COUNT;
  assign busy    = full;
  assign push    = start && !full;

  always_comb begin
    cmd.node    = node_index;
    cmd.hart    = hart;
    cmd.hart_ok = hart_ok;
    unique case (mode)
      phrq_pkg::MODE_BIND: cmd.op = node_ok ? phrq_pkg::OP_BIND : phrq_pkg::OP_FAIL;
      phrq_pkg::MODE_PUSH: cmd.op = node_ok ? phrq_pkg::OP_PUSH : phrq_pkg::OP_FAIL;
      phrq_pkg::MODE_POP:  cmd.op = hart_ok ? phrq_pkg::OP_POP : phrq_pkg::OP_FAIL;
      default:             cmd.op = phrq_pkg::OP_FAIL;
    endcase
  end

endmodule

`default_nettype wire

/* design/phrq_cmd_fifo.sv */
// short command queue between front and back end
`default_nettype none

module phrq_cmd_fifo #(
  parameter int DEPTH = phrq_pkg::CMDQ_DEPTH
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire phrq_pkg::cmd_t push_data,
  output logic                full,
  input  wire logic           pop,
  output phrq_pkg::cmd_t      pop_data,
  output logic                empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  phrq_pkg::cmd_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full     = count == CNT_W'(DEPTH);
  assign empty    = count == '0;
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* design/phrq_back.sv */
// back end: queue state, node memories and the operation sequencer
`default_nettype none

module phrq_back #(
  parameter int HART_COUNT = phrq_pkg::HART_COUNT_DEF,
  parameter int NODE_COUNT = phrq_pkg::NODE_COUNT_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire phrq_pkg::cmd_t cmd,
  input  wire logic          empty,
  output logic               pop,
  output logic               done,
  output logic               ok,
  output logic [7:0]         popped_node
);

  localparam int NIDX_W = $clog2(NODE_COUNT);
  localparam int HIDX_W = (HART_COUNT > 1) ? $clog2(HART_COUNT) : 1;

  phrq_pkg::state_t state;
  phrq_pkg::state_t state_next;
  phrq_pkg::cmd_t   cur;

  logic [HIDX_W:0]   own_mem [NODE_COUNT];
  logic [NIDX_W:0]   lnk_mem [NODE_COUNT];
  logic [HIDX_W:0]   owner_rd;
  logic [NIDX_W:0]   link_rd;

  logic [NIDX_W-1:0] head [HART_COUNT];
  logic [NIDX_W-1:0] tail [HART_COUNT];
  logic [HART_COUNT-1:0] nonempty;
  logic [NIDX_W-1:0] tail_save;

  logic [NIDX_W-1:0] in_node;
  logic [HIDX_W-1:0] in_hart;
  logic [NIDX_W-1:0] cur_node;
  logic [HIDX_W-1:0] pop_hart;
  logic [HIDX_W-1:0] own_hart;
  logic              own_ok;
  logic [NIDX_W-1:0] pop_head;

  logic              own_we;
  logic              own_re;
  logic              lnk_we;
  logic [NIDX_W-1:0] lnk_waddr;
  logic [NIDX_W:0]   lnk_wdata;
  logic              lnk_re;
  logic [NIDX_W-1:0] lnk_raddr;
  logic [HIDX_W-1:0] q_idx;
  logic              head_we;
  logic [NIDX_W-1:0] head_wdata;
  logic              tail_we;
  logic              ne_we;
  logic              ne_wdata;
  logic              save_tail;
  logic              res_valid;
  logic              res_ok;
  logic [NIDX_W-1:0] res_node;

  assign in_node  = NIDX_W'(cmd.node);
  assign in_hart  = HIDX_W'(cmd.hart);
  assign cur_node = NIDX_W'(cur.node);
  assign pop_hart = HIDX_W'(cur.hart);
  assign own_hart = owner_rd[HIDX_W-1:0];
  assign own_ok   = owner_rd[HIDX_W];
  assign pop_head = head[pop_hart];

  always_comb begin
    state_next = state;
    unique case (state)
      phrq_pkg::ST_IDLE: begin
        if (!empty) begin
          if (cmd.op == phrq_pkg::OP_PUSH) begin
            state_next = phrq_pkg::ST_OWNER;
          end else if (cmd.op == phrq_pkg::OP_POP && nonempty[in_hart]) begin
            state_next = phrq_pkg::ST_POP;
          end
        end
      end
      phrq_pkg::ST_OWNER: begin
        state_next = (own_ok && nonempty[own_hart]) ? phrq_pkg::ST_LINK : phrq_pkg::ST_IDLE;
      end
      phrq_pkg::ST_LINK: state_next = phrq_pkg::ST_IDLE;
      phrq_pkg::ST_POP:  state_next = phrq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    pop        = 1'b0;
    own_we     = 1'b0;
    own_re     = 1'b0;
    lnk_we     = 1'b0;
    lnk_waddr  = in_node;
    lnk_wdata  = '0;
    lnk_re     = 1'b0;
    lnk_raddr  = head[in_hart];
    q_idx      = own_hart;
    head_we    = 1'b0;
    head_wdata = cur_node;
    tail_we    = 1'b0;
    ne_we      = 1'b0;
    ne_wdata   = 1'b0;
    save_tail  = 1'b0;
    res_valid  = 1'b0;
    res_ok     = 1'b0;
    res_node   = '0;
    unique case (state)
      phrq_pkg::ST_IDLE: begin
        if (!empty) begin
          pop = 1'b1;
          unique case (cmd.op)
            phrq_pkg::OP_BIND: begin
              own_we    = 1'b1;
              lnk_we    = 1'b1;
              res_valid = 1'b1;
              res_ok    = 1'b1;
            end
            phrq_pkg::OP_PUSH: own_re = 1'b1;
            phrq_pkg::OP_POP: begin
              if (nonempty[in_hart]) begin
                lnk_re = 1'b1;
              end else begin
                res_valid = 1'b1;
              end
            end
            phrq_pkg::OP_FAIL: res_valid = 1'b1;
          endcase
        end
      end
      phrq_pkg::ST_OWNER: begin
        if (!own_ok) begin
          res_valid = 1'b1;
        end else begin
          lnk_we    = 1'b1;
          lnk_waddr = cur_node;
          tail_we   = 1'b1;
          if (nonempty[own_hart]) begin
            save_tail = 1'b1;
          end else begin
            head_we   = 1'b1;
            ne_we     = 1'b1;
            ne_wdata  = 1'b1;
            res_valid = 1'b1;
            res_ok    = 1'b1;
          end
        end
      end
      phrq_pkg::ST_LINK: begin
        lnk_we    = 1'b1;
        lnk_waddr = tail_save;
        lnk_wdata = {1'b1, cur_node};
        res_valid = 1'b1;
        res_ok    = 1'b1;
      end
      phrq_pkg::ST_POP: begin
        q_idx     = pop_hart;
        lnk_we    = 1'b1;
        lnk_waddr = pop_head;
        if (link_rd[NIDX_W]) begin
          head_we    = 1'b1;
          head_wdata = link_rd[NIDX_W-1:0];
        end else begin
          ne_we = 1'b1;
        end
        res_valid = 1'b1;
        res_ok    = 1'b1;
        res_node  = pop_head;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (own_we) begin
      own_mem[in_node] <= {cmd.hart_ok, in_hart};
    end
    if (own_re) begin
      owner_rd <= own_mem[in_node];
    end
  end

  always_ff @(posedge clk) begin
    if (lnk_we) begin
      lnk_mem[lnk_waddr] <= lnk_wdata;
    end
    if (lnk_re) begin
      link_rd <= lnk_mem[lnk_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= cmd;
    end
    if (save_tail) begin
      tail_save <= tail[own_hart];
    end
    if (head_we) begin
      head[q_idx] <= head_wdata;
    end
    if (tail_we) begin
      tail[q_idx] <= cur_node;
    end
    ok          <= res_ok;
    popped_node <= 8'(res_node);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= phrq_pkg::ST_IDLE;
      nonempty <= '0;
      done     <= 1'b0;
    end else begin
      state <= state_next;
      if (ne_we) begin
        nonempty[q_idx] <= ne_wdata;
      end
      done <= res_valid;
    end
  end

endmodule

`default_nettype wire

/* design/per_hart_linked_run_queues_core.sv */
// top level of the per-hart linked run queue block
//
// commands enter on start with mode, node_index and hart; a command beat is
// taken at a rising edge where start is high and busy is low. mode 0 binds a
// node to a hart, mode 1 appends a node to its hart's queue, mode 2 pops the
// head of a hart's queue.
// every command gives one result beat: done is high for one cycle with ok
// and popped_node, and the result is taken at the edge that ends that cycle.
// the receiver cannot hold results off.
// a two-entry command queue parts the front end from the sequencer, so busy
// rises only while both entries are held.
// an accepted command passes through the command queue to the sequencer,
// which answers a bind, an unused mode or an empty pop in its idle state, a
// pop in its pop state and a push in its owner state, or in its link state
// for a push onto a nonempty queue; the sequencer takes a new command only
// in its idle state, kept out of it by the registered reads of the owner and
// link memories and the single write port of the link memory.
// reset clears the command queue, the sequencer and the per-hart nonempty
// flags; node memories and head and tail entries hold their contents, which
// the user must write before they are read; the block does not enforce it.
`default_nettype none

module per_hart_linked_run_queues_core #(
  parameter int HART_COUNT = phrq_pkg::HART_COUNT_DEF,
  parameter int NODE_COUNT = phrq_pkg::NODE_COUNT_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  mode,
  input  wire logic [7:0]  node_index,
  input  wire logic [15:0] hart,
  output logic             done,
  output logic             ok,
  output logic [7:0]       popped_node
);

  phrq_pkg::cmd_t front_cmd;
  phrq_pkg::cmd_t back_cmd;
  logic           fifo_push;
  logic           fifo_full;
  logic           fifo_pop;
  logic           fifo_empty;

  phrq_front #(
    .HART_COUNT (HART_COUNT),
    .NODE_COUNT (NODE_COUNT)
  ) u_front (
    .start      (start),
    .mode       (mode),
    .node_index (node_index),
    .hart       (hart),
    .full       (fifo_full),
    .busy       (busy),
    .push       (fifo_push),
    .cmd        (front_cmd)
  );

  phrq_cmd_fifo #(
    .DEPTH (phrq_pkg::CMDQ_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (fifo_push),
    .push_data (front_cmd),
    .full      (fifo_full),
    .pop       (fifo_pop),
    .pop_data  (back_cmd),
    .empty     (fifo_empty)
  );

  phrq_back #(
    .HART_COUNT (HART_COUNT),
    .NODE_COUNT (NODE_COUNT)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd         (back_cmd),
    .empty       (fifo_empty),
    .pop         (fifo_pop),
    .done        (done),
    .ok          (ok),
    .popped_node (popped_node)
  );

endmodule

`default_nettype wire

/* design/phrq_checker.sv */
// port-level checks for the run queue block and their bind
`default_nettype none
`include "assert_macros.svh"

module phrq_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        start,
  input wire logic        busy,
  input wire logic [1:0]  mode,
  input wire logic [7:0]  node_index,
  input wire logic [15:0] hart,
  input wire logic        done,
  input wire logic        ok,
  input wire logic [7:0]  popped_node
);

  logic cmd_seen;

  assign cmd_seen = (mode != 2'd3) || (node_index != 8'd0) || (hart != 16'd0) || 1'b1;

  // no result beat in the cycle after reset
  `PHRQ_ASSERT_ALWAYS(a_no_done_after_rst, clk, rst |=> !done)
  // command queue comes out of reset empty
  `PHRQ_ASSERT_ALWAYS(a_idle_after_rst, clk, rst |=> !busy)
  // a failed result carries no node
  `PHRQ_ASSERT(a_fail_no_node, clk, rst, (done && !ok) |-> (popped_node == 8'd0))
  // busy only rises after a command beat was taken
  `PHRQ_ASSERT(a_busy_from_accept, clk, rst, $rose(busy) |-> $past(start && !busy && cmd_seen))

endmodule

bind per_hart_linked_run_queues_core phrq_checker u_phrq_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .mode        (mode),
  .node_index  (node_index),
  .hart        (hart),
  .done        (done),
  .ok          (ok),
  .popped_node (popped_node)
);

`default_nettype wire
